### rtl/stk500v2_frame_builder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef STK500V2_FRAME_BUILDER_MACROS_SVH
`define STK500V2_FRAME_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define S2FB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define S2FB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S2FB_ASSERT(lbl, clk, rst_n, prop, msg)
`define S2FB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/s2fb_pkg.sv
// ----------------------------------------------------------------------------
// s2fb_pkg
// Types and constants of the STK500v2 frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package s2fb_pkg;

    localparam logic [7:0] START_BYTE = 8'h1B;
    localparam logic [7:0] TOKEN_BYTE = 8'h0E;

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // One classified body word as it waits for the back end
    typedef struct packed {
        logic [7:0]  body_byte;
        logic [15:0] body_length;
        logic [7:0]  seq_num;
        logic        first_byte;
        logic        last_byte;
    } entry_t;

    // Push side of the queue
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Pop side of the queue as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    // Which byte of the frame the back end emits next
    typedef enum logic [2:0] {
        PH_HEAD,
        PH_SEQ,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TOKEN,
        PH_BODY,
        PH_CSUM
    } phase_t;

endpackage

`default_nettype wire

### rtl/s2fb_if.sv
// ----------------------------------------------------------------------------
// s2fb_if
// Valid/ready channels of the frame builder: body words in, frame words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2fb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  body_byte;
    logic [15:0] body_length;
    logic        first_byte;
    logic        last_byte;

    modport source (output valid, body_byte, body_length, first_byte, last_byte,
                    input ready);
    modport sink   (input valid, body_byte, body_length, first_byte, last_byte,
                    output ready);
endinterface

interface s2fb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

`default_nettype wire

### rtl/s2fb_front.sv
// ----------------------------------------------------------------------------
// s2fb_front
// Accepts body words, numbers each new frame and queues the classified word.
// ----------------------------------------------------------------------------
`default_nettype none

module s2fb_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    s2fb_in_if.sink             body_in,
    output s2fb_pkg::push_t     push,
    input  wire logic           push_ready
);

    logic [7:0] seq_reg;
    logic [7:0] seq_next;
    logic [7:0] seq_inc;
    logic       accept;

    // Hand the word on whenever the queue has room
    assign body_in.ready = push_ready;
    assign accept        = body_in.valid && push_ready;
    assign seq_inc       = seq_reg + 8'd1;

    // Advance the sequence number on every first word
    always_comb
    begin
        seq_next = seq_reg;
        if (accept && body_in.first_byte)
        begin
            seq_next = seq_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= 8'd0;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    // Build the queue entry
    always_comb
    begin
        push.valid             = body_in.valid;
        push.entry.body_byte   = body_in.body_byte;
        push.entry.body_length = body_in.body_length;
        push.entry.seq_num     = seq_inc;
        push.entry.first_byte  = body_in.first_byte;
        push.entry.last_byte   = body_in.last_byte;
    end

endmodule

`default_nettype wire

### rtl/s2fb_fifo.sv
// ----------------------------------------------------------------------------
// s2fb_fifo
// Short queue of classified body words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stk500v2_frame_builder_macros.svh"

module s2fb_fifo #(
    parameter int DEPTH = s2fb_pkg::FIFO_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire s2fb_pkg::push_t push,
    output logic                push_ready,
    output s2fb_pkg::head_t     head,
    input  wire logic           pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    s2fb_pkg::entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `S2FB_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `S2FB_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> head.valid, "pop from empty queue")
    `S2FB_ASSERT(a_head_hold, clk, rst_n, (head.valid && !pop) |=> $stable(head.entry), "queue head changed while held")

endmodule

`default_nettype wire

### rtl/s2fb_back.sv
// ----------------------------------------------------------------------------
// s2fb_back
// Expands queued words into frame words: header, body and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stk500v2_frame_builder_macros.svh"

module s2fb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire s2fb_pkg::head_t head,
    output logic                pop,
    s2fb_out_if.source          frame_out
);

    s2fb_pkg::phase_t state_reg;
    s2fb_pkg::phase_t state_next;

    logic [7:0] csum_reg;
    logic [7:0] csum_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       advance;
    logic       emit;
    logic       emit_end;
    logic [7:0] emit_byte;

    // Load a new word when the output register is empty or being taken
    assign advance = !out_valid_reg || frame_out.ready;

    // Pick the next frame word and keep the running checksum
    always_comb
    begin
        state_next = state_reg;
        csum_next  = csum_reg;
        emit       = 1'b0;
        emit_end   = 1'b0;
        emit_byte  = head.entry.body_byte;
        pop        = 1'b0;
        if (advance)
        begin
            unique case (state_reg)
                s2fb_pkg::PH_HEAD:
                begin
                    if (head.valid)
                    begin
                        emit = 1'b1;
                        if (head.entry.first_byte)
                        begin
                            emit_byte  = s2fb_pkg::START_BYTE;
                            csum_next  = s2fb_pkg::START_BYTE;
                            state_next = s2fb_pkg::PH_SEQ;
                        end
                        else
                        begin
                            csum_next  = csum_reg ^ head.entry.body_byte;
                            pop        = 1'b1;
                            state_next = head.entry.last_byte ? s2fb_pkg::PH_CSUM
                                                              : s2fb_pkg::PH_HEAD;
                        end
                    end
                end
                s2fb_pkg::PH_SEQ:
                begin
                    emit       = 1'b1;
                    emit_byte  = head.entry.seq_num;
                    csum_next  = csum_reg ^ head.entry.seq_num;
                    state_next = s2fb_pkg::PH_LEN_HI;
                end
                s2fb_pkg::PH_LEN_HI:
                begin
                    emit       = 1'b1;
                    emit_byte  = head.entry.body_length[15:8];
                    csum_next  = csum_reg ^ head.entry.body_length[15:8];
                    state_next = s2fb_pkg::PH_LEN_LO;
                end
                s2fb_pkg::PH_LEN_LO:
                begin
                    emit       = 1'b1;
                    emit_byte  = head.entry.body_length[7:0];
                    csum_next  = csum_reg ^ head.entry.body_length[7:0];
                    state_next = s2fb_pkg::PH_TOKEN;
                end
                s2fb_pkg::PH_TOKEN:
                begin
                    emit       = 1'b1;
                    emit_byte  = s2fb_pkg::TOKEN_BYTE;
                    csum_next  = csum_reg ^ s2fb_pkg::TOKEN_BYTE;
                    state_next = s2fb_pkg::PH_BODY;
                end
                s2fb_pkg::PH_BODY:
                begin
                    emit       = 1'b1;
                    csum_next  = csum_reg ^ head.entry.body_byte;
                    pop        = 1'b1;
                    state_next = head.entry.last_byte ? s2fb_pkg::PH_CSUM
                                                      : s2fb_pkg::PH_HEAD;
                end
                s2fb_pkg::PH_CSUM:
                begin
                    emit       = 1'b1;
                    emit_end   = 1'b1;
                    emit_byte  = csum_reg;
                    csum_next  = 8'd0;
                    state_next = s2fb_pkg::PH_HEAD;
                end
                default:
                begin
                    state_next = s2fb_pkg::PH_HEAD;
                end
            endcase
        end
    end

    assign out_valid_next = advance ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= s2fb_pkg::PH_HEAD;
            csum_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            csum_reg      <= csum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output word until taken
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_byte_reg <= emit_byte;
            out_end_reg  <= emit_end;
        end
    end

    assign frame_out.valid      = out_valid_reg;
    assign frame_out.frame_byte = out_byte_reg;
    assign frame_out.frame_end  = out_end_reg;

    `S2FB_ASSERT(a_start_held, clk, rst_n, (state_reg == s2fb_pkg::PH_SEQ) |-> (out_valid_reg && out_byte_reg == s2fb_pkg::START_BYTE), "start word not held before sequence number")
    `S2FB_ASSERT(a_end_then_head, clk, rst_n, (out_valid_reg && out_end_reg) |-> (state_reg == s2fb_pkg::PH_HEAD), "checksum word shown outside frame close")
    `S2FB_ASSERT(a_pop_on_body, clk, rst_n, pop |-> (state_reg == s2fb_pkg::PH_HEAD || state_reg == s2fb_pkg::PH_BODY), "entry released before its body word")

endmodule

`default_nettype wire

### rtl/stk500v2_frame_builder.sv
// ----------------------------------------------------------------------------
// stk500v2_frame_builder
// Wraps body words into STK500v2 frames with header and XOR checksum.
// ----------------------------------------------------------------------------
//  channel     dir   handshake      payload
//  body_in     in    valid/ready    body_byte, body_length, first_byte, last_byte
//  frame_out   out   valid/ready    frame_byte, frame_end
//
//  The back end emits one frame word per cycle from a registered output,
//  stalling while frame_out is not ready. A body word alone yields one frame
//  word; a first word adds five header words and a last word one checksum word.
//  The queue of FIFO_DEPTH words absorbs those extra words, so the input
//  stalls only while the queue is full. Reset clears the sequence number,
//  the checksum, the frame phase, the queue and the output valid; nothing
//  else is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stk500v2_frame_builder #(
    parameter int FIFO_DEPTH = s2fb_pkg::FIFO_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    s2fb_in_if.sink     body_in,
    s2fb_out_if.source  frame_out
);

    s2fb_pkg::push_t push;
    s2fb_pkg::head_t head;
    logic            push_ready;
    logic            pop;

    // Accept and number body words
    s2fb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_in    (body_in),
        .push       (push),
        .push_ready (push_ready)
    );

    // Decouple intake from frame expansion
    s2fb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // Expand into frame words
    s2fb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .frame_out (frame_out)
    );

endmodule

`default_nettype wire
